// ===== src/bts_pkg.sv =====
package bts_pkg;

  localparam int TEX_SIDE     = 256;
  localparam int TEX_COORD_W  = $clog2(TEX_SIDE);
  localparam int FRAC_W       = 8;
  localparam int COORD_W      = 18;
  localparam int CLAMP_W      = 17;
  localparam int COORD_ONE    = 65536;
  localparam int CHAN_W       = 8;
  localparam int TEXEL_W      = 3 * CHAN_W;
  localparam int LEVEL_W      = 16;
  localparam int HBLEND_W     = 16;
  localparam int VSUM_W       = 24;
  localparam int BANK_ADDR_W  = 2 * (TEX_COORD_W - 1);
  localparam int BANK_DEPTH   = 1 << BANK_ADDR_W;
  localparam int IN_DATA_W    = 80;
  localparam int OUT_DATA_W   = 48;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef logic [TEX_COORD_W-1:0] tcoord_t;
  typedef logic [FRAC_W-1:0]      frac_t;
  typedef logic [TEXEL_W-1:0]     texel_t;
  typedef logic [BANK_ADDR_W-1:0] bank_addr_t;

  // item after coordinate setup; a write keeps its address in x0/y0
  typedef struct packed {
    op_t     op;
    tcoord_t x0;
    tcoord_t x1;
    tcoord_t y0;
    tcoord_t y1;
    frac_t   fu;
    frac_t   fv;
    texel_t  wdata;
  } setup_t;

  // bank selection and fractions carried past the texture read
  typedef struct packed {
    logic  x0_odd;
    logic  x1_odd;
    logic  y0_odd;
    logic  y1_odd;
    frac_t fu;
    frac_t fv;
  } fetch_t;

  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    bank_addr_t waddr;
    bank_addr_t raddr;
    texel_t     wdata;
  } bank_ctl_t;

endpackage

// ===== src/bts_tex_bank.sv =====
module bts_tex_bank (
  input  logic               clk,
  input  bts_pkg::bank_ctl_t ctl,
  output bts_pkg::texel_t    rdata
);

  bts_pkg::texel_t mem [bts_pkg::BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[ctl.raddr];
    end
  end

endmodule

// ===== src/bilinear_rgb_texture_sampler.sv =====
// a sample item passes the setup, bank read, horizontal blend and vertical blend registers to out_tvalid
// throughput: one item per cycle unless out_tready stalls the pipeline, writes and samples mixed freely
// the texture sits in four banks split by column and row parity, so the four
//   neighbors of a sample are read together through one port per bank
// reset clears the pipeline valid bits only; texels are undefined until written
module bilinear_rgb_texture_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // u_coord, v_coord, texel_x, texel_y, red_in, green_in, blue_in, zero pad
  input  logic [79:0] in_tdata,
  // op
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // red_level, green_level, blue_level
  output logic [47:0] out_tdata
);

  localparam int TC = bts_pkg::TEX_COORD_W;
  localparam int CW = bts_pkg::CHAN_W;

  // ---------------------------------------------------------------- control
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign out_tvalid = v4_r;

  // ---------------------------------------------------------------- stage 1
  logic signed [bts_pkg::COORD_W-1:0] u_in, v_in;
  logic [bts_pkg::CLAMP_W-1:0]        uc, vc;
  bts_pkg::setup_t                    s1_nxt, s1_r;
  bts_pkg::tcoord_t                   xi, yi;

  assign u_in = in_tdata[17:0];
  assign v_in = in_tdata[35:18];

  always_comb begin
    if (u_in[bts_pkg::COORD_W-1]) begin
      uc = '0;
    end else if (u_in > bts_pkg::COORD_W'(bts_pkg::COORD_ONE)) begin
      uc = bts_pkg::CLAMP_W'(bts_pkg::COORD_ONE);
    end else begin
      uc = u_in[bts_pkg::CLAMP_W-1:0];
    end
    if (v_in[bts_pkg::COORD_W-1]) begin
      vc = '0;
    end else if (v_in > bts_pkg::COORD_W'(bts_pkg::COORD_ONE)) begin
      vc = bts_pkg::CLAMP_W'(bts_pkg::COORD_ONE);
    end else begin
      vc = v_in[bts_pkg::CLAMP_W-1:0];
    end
    // integer part of 1.0 lands one past the last texel
    xi = uc[bts_pkg::CLAMP_W-1] ? '1 : uc[bts_pkg::FRAC_W +: TC];
    yi = vc[bts_pkg::CLAMP_W-1] ? '1 : vc[bts_pkg::FRAC_W +: TC];

    s1_nxt.op    = bts_pkg::op_t'(in_tuser);
    s1_nxt.fu    = uc[bts_pkg::FRAC_W-1:0];
    s1_nxt.fv    = vc[bts_pkg::FRAC_W-1:0];
    s1_nxt.wdata = {in_tdata[59:52], in_tdata[67:60], in_tdata[75:68]};
    if (in_tuser == bts_pkg::OP_WRITE) begin
      s1_nxt.x0 = in_tdata[43:36];
      s1_nxt.y0 = in_tdata[51:44];
    end else begin
      s1_nxt.x0 = xi;
      s1_nxt.y0 = yi;
    end
    s1_nxt.x1 = (xi == '1) ? xi : xi + TC'(1);
    s1_nxt.y1 = (yi == '1) ? yi : yi + TC'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic               adv12;
  bts_pkg::bank_ctl_t bank_ctl [4];
  bts_pkg::texel_t    bank_q   [4];
  bts_pkg::fetch_t    s2_nxt, s2_r;

  assign adv12 = v1_r && rdy2;

  // bank index is {row parity, column parity}
  for (genvar b = 0; b < 4; b++) begin : g_bank
    always_comb begin
      bts_pkg::tcoord_t rc, rr;
      rc = (s1_r.x0[0] == b[0]) ? s1_r.x0 : s1_r.x1;
      rr = (s1_r.y0[0] == b[1]) ? s1_r.y0 : s1_r.y1;
      bank_ctl[b].wr_en = adv12 && (s1_r.op == bts_pkg::OP_WRITE) &&
                          (s1_r.x0[0] == b[0]) && (s1_r.y0[0] == b[1]);
      bank_ctl[b].rd_en = adv12 && (s1_r.op == bts_pkg::OP_SAMPLE);
      bank_ctl[b].waddr = {s1_r.y0[TC-1:1], s1_r.x0[TC-1:1]};
      bank_ctl[b].raddr = {rr[TC-1:1], rc[TC-1:1]};
      bank_ctl[b].wdata = s1_r.wdata;
    end

    bts_tex_bank u_bank (
      .clk   (clk),
      .ctl   (bank_ctl[b]),
      .rdata (bank_q[b])
    );
  end

  always_comb begin
    s2_nxt.x0_odd = s1_r.x0[0];
    s2_nxt.x1_odd = s1_r.x1[0];
    s2_nxt.y0_odd = s1_r.y0[0];
    s2_nxt.y1_odd = s1_r.y1[0];
    s2_nxt.fu     = s1_r.fu;
    s2_nxt.fv     = s1_r.fv;
  end

  // write items stop here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r && (s1_r.op == bts_pkg::OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv12) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3
  bts_pkg::texel_t t00, t10, t01, t11;
  logic [bts_pkg::FRAC_W:0] fu_inv;
  logic [bts_pkg::HBLEND_W-1:0] top_nxt [3];
  logic [bts_pkg::HBLEND_W-1:0] bot_nxt [3];
  logic [bts_pkg::HBLEND_W-1:0] top_r   [3];
  logic [bts_pkg::HBLEND_W-1:0] bot_r   [3];
  bts_pkg::frac_t fv3_r;

  assign t00 = bank_q[{s2_r.y0_odd, s2_r.x0_odd}];
  assign t10 = bank_q[{s2_r.y0_odd, s2_r.x1_odd}];
  assign t01 = bank_q[{s2_r.y1_odd, s2_r.x0_odd}];
  assign t11 = bank_q[{s2_r.y1_odd, s2_r.x1_odd}];
  assign fu_inv = (bts_pkg::FRAC_W+1)'(1 << bts_pkg::FRAC_W) - {1'b0, s2_r.fu};

  // channel 0 is red in the top byte of a texel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [CW-1:0] a, b, p, q;
      logic [bts_pkg::HBLEND_W:0] st, sb;
      a = t00[(2-c)*CW +: CW];
      b = t10[(2-c)*CW +: CW];
      p = t01[(2-c)*CW +: CW];
      q = t11[(2-c)*CW +: CW];
      st = (bts_pkg::HBLEND_W+1)'(a * fu_inv) + (bts_pkg::HBLEND_W+1)'(b * s2_r.fu);
      sb = (bts_pkg::HBLEND_W+1)'(p * fu_inv) + (bts_pkg::HBLEND_W+1)'(q * s2_r.fu);
      top_nxt[c] = st[bts_pkg::HBLEND_W-1:0];
      bot_nxt[c] = sb[bts_pkg::HBLEND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
      fv3_r <= s2_r.fv;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [bts_pkg::FRAC_W:0]    fv_inv;
  logic [bts_pkg::LEVEL_W-1:0] lvl_nxt [3];
  logic [bts_pkg::LEVEL_W-1:0] lvl_r   [3];

  assign fv_inv = (bts_pkg::FRAC_W+1)'(1 << bts_pkg::FRAC_W) - {1'b0, fv3_r};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [bts_pkg::VSUM_W-1:0] s;
      s = bts_pkg::VSUM_W'(top_r[c] * fv_inv) + bts_pkg::VSUM_W'(bot_r[c] * fv3_r)
          + bts_pkg::VSUM_W'(1 << (bts_pkg::FRAC_W - 1));
      lvl_nxt[c] = s[bts_pkg::FRAC_W +: bts_pkg::LEVEL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && rdy4) begin
      lvl_r <= lvl_nxt;
    end
  end

  assign out_tdata = {lvl_r[2], lvl_r[1], lvl_r[0]};

endmodule
